[rtl/core/sjt_pkg.sv]
// ----------------------------------------------------------------------------
// sjt_pkg
// Shared constants and types of the switch jump-table search engine.
// ----------------------------------------------------------------------------
package sjt_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned DataW      = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] label;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } wr_req_t;

endpackage

[rtl/core/sjt_table.sv]
// ----------------------------------------------------------------------------
// sjt_table
// Case table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sjt_table (
  input  logic            clk_i,
  input  sjt_pkg::wr_req_t wr_i,
  input  sjt_pkg::idx_t   rd_addr_i,
  output sjt_pkg::entry_t rd_data_o
);

  sjt_pkg::entry_t mem_q [sjt_pkg::MaxEntries];
  sjt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/switch_jump_table_search.sv]
// ----------------------------------------------------------------------------
// switch_jump_table_search
// Switch-statement jump table: append case entries, then binary-search a key.
// ----------------------------------------------------------------------------
// Add and clear beats leave the engine idle; the next beat is accepted right after.
// A lookup on N entries makes P = M + 2 probes, one table read per cycle, with M
// at most ceil(log2(N-1)) midpoints (none for one entry); a hit ends it early.
// The result passes through a done state, which waits until the output register
// is free, into that register; the next beat is taken once the engine is idle
// again; an empty table skips the probes. Reset and each lookup empty the table.
module switch_jump_table_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] key_value, [63:32] label_address, [95:64] default_address
  input  logic [95:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] jump_address
  output logic [31:0] m_axis_tdata,
  // [0] matched
  output logic        m_axis_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PK_MID,
    PK_HI,
    PK_LO
  } probe_e;

  localparam int unsigned IdxW = sjt_pkg::IdxW;
  localparam int unsigned DW   = sjt_pkg::DataW;

  state_e         state_q, state_d;
  probe_e         kind_q, kind_d;
  sjt_pkg::cnt_t  count_q, count_d;
  sjt_pkg::idx_t  lo_q, lo_d, hi_q, hi_d, addr_q, rd_addr;
  logic [DW-1:0]  key_q, key_d, dflt_q, dflt_d;
  logic [DW-1:0]  res_addr_q, res_addr_d;
  logic           res_match_q, res_match_d;
  logic           out_valid_q, out_valid_d;
  logic [DW-1:0]  out_addr_q, out_addr_d;
  logic           out_match_q, out_match_d;

  sjt_pkg::wr_req_t wr_req;
  sjt_pkg::entry_t  rd_data;
  sjt_pkg::cmd_e    in_cmd;
  logic             in_fire;
  logic             hit;
  sjt_pkg::idx_t    nlo, nhi, first_hi;

  function automatic logic far_apart(sjt_pkg::idx_t lo, sjt_pkg::idx_t hi);
    logic [IdxW-1:0] diff;
    diff = hi - lo;
    return diff > IdxW'(1);
  endfunction

  function automatic sjt_pkg::idx_t midpoint(sjt_pkg::idx_t lo, sjt_pkg::idx_t hi);
    logic [IdxW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[IdxW:1];
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = sjt_pkg::cmd_e'(s_axis_tuser);
  assign hit           = (rd_data.value == key_q);
  assign first_hi      = IdxW'(count_q - sjt_pkg::cnt_t'(1));

  // Writes happen only in idle on an add; reads that matter start at a lookup,
  // so the two never touch the same entry in one cycle.
  always_comb begin
    wr_req.en         = in_fire && (in_cmd == sjt_pkg::CMD_ADD) &&
                        (count_q < sjt_pkg::cnt_t'(sjt_pkg::MaxEntries));
    wr_req.addr       = IdxW'(count_q);
    wr_req.data.value = s_axis_tdata[31:0];
    wr_req.data.label = s_axis_tdata[63:32];
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    key_d       = key_q;
    dflt_d      = dflt_q;
    res_addr_d  = res_addr_q;
    res_match_d = res_match_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_match_d = out_match_q;
    rd_addr     = addr_q;
    nlo         = lo_q;
    nhi         = hi_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            sjt_pkg::CMD_ADD: begin
              if (wr_req.en) begin
                count_d = count_q + sjt_pkg::cnt_t'(1);
              end
            end
            sjt_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            sjt_pkg::CMD_LOOKUP: begin
              key_d   = s_axis_tdata[31:0];
              dflt_d  = s_axis_tdata[95:64];
              count_d = '0;
              lo_d    = '0;
              hi_d    = first_hi;
              if (count_q == '0) begin
                res_addr_d  = s_axis_tdata[95:64];
                res_match_d = 1'b0;
                state_d     = ST_DONE;
              end else begin
                state_d = ST_PROBE;
                if (far_apart('0, first_hi)) begin
                  kind_d  = PK_MID;
                  rd_addr = midpoint('0, first_hi);
                end else begin
                  kind_d  = PK_HI;
                  rd_addr = first_hi;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        if (hit) begin
          res_addr_d  = rd_data.label;
          res_match_d = 1'b1;
          state_d     = ST_DONE;
        end else begin
          case (kind_q)
            PK_MID: begin
              // Narrow the bounds around the probed midpoint.
              if ($signed(key_q) <= $signed(rd_data.value)) begin
                nhi = addr_q;
              end else begin
                nlo = addr_q;
              end
              lo_d = nlo;
              hi_d = nhi;
              if (far_apart(nlo, nhi)) begin
                kind_d  = PK_MID;
                rd_addr = midpoint(nlo, nhi);
              end else begin
                kind_d  = PK_HI;
                rd_addr = nhi;
              end
            end
            PK_HI: begin
              kind_d  = PK_LO;
              rd_addr = lo_q;
            end
            default: begin
              res_addr_d  = dflt_q;
              res_match_d = 1'b0;
              state_d     = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_match_d = res_match_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= PK_MID;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    addr_q      <= rd_addr;
    key_q       <= key_d;
    dflt_q      <= dflt_d;
    res_addr_q  <= res_addr_d;
    res_match_q <= res_match_d;
    out_addr_q  <= out_addr_d;
    out_match_q <= out_match_d;
  end

  sjt_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_match_q;

endmodule
